[rtl/core/moving_average_rate_of_change_defines.svh]
// Assertion macros shared by the moving average block.
// Depends on clk and rst_n being visible in the module that includes it.
`ifndef MOVING_AVERAGE_RATE_OF_CHANGE_DEFINES_SVH
`define MOVING_AVERAGE_RATE_OF_CHANGE_DEFINES_SVH

// checked only outside reset
`define MARC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define MARC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/marc_pkg.sv]
// Constants, divider types and the divider step function for the moving average block.
// No dependencies.
package marc_pkg;

    localparam int MAX_WINDOW  = 32;
    localparam int SAMPLE_BITS = 24;
    localparam int PTR_BITS    = $clog2(MAX_WINDOW);
    localparam int LEN_BITS    = 6;
    localparam int SUM_BITS    = SAMPLE_BITS + PTR_BITS;
    localparam int AVG_BITS    = 32;
    localparam int PCT_BITS    = 32;
    localparam int PCT_SCALE   = 25600;
    localparam int SCALE_BITS  = $clog2(PCT_SCALE + 1);
    localparam int PROD_BITS   = AVG_BITS + SCALE_BITS;

    // shared divider: dividend shift register, remainder, two quotient bits per cycle
    localparam int DIV_BITS    = ((PROD_BITS + 1) / 2) * 2;
    localparam int AVG_Q_BITS  = ((SUM_BITS + 8 + 1) / 2) * 2;
    localparam int AVG_CYCLES  = AVG_Q_BITS / 2;
    localparam int PCT_CYCLES  = DIV_BITS / 2;
    localparam int CNT_BITS    = $clog2(PCT_CYCLES);

    typedef struct packed {
        logic [AVG_BITS-1:0] rem;
        logic [DIV_BITS-1:0] dvd;
    } div_state_t;

    // one restoring step: shift in the next dividend bit, shift out one quotient bit
    function automatic div_state_t div_step(input div_state_t cur,
                                            input logic [AVG_BITS-1:0] divisor);
        logic [AVG_BITS:0] trial;
        logic              qbit;
        div_state_t        nxt;
        trial = {cur.rem, cur.dvd[DIV_BITS-1]};
        qbit  = (trial >= {1'b0, divisor});
        if (qbit)
        begin
            trial = trial - {1'b0, divisor};
        end
        nxt.rem = trial[AVG_BITS-1:0];
        nxt.dvd = {cur.dvd[DIV_BITS-2:0], qbit};
        return nxt;
    endfunction

endpackage

[rtl/core/moving_average_rate_of_change.sv]
// Moving average over the last N samples with percent change of the average.
// Depends on marc_pkg and moving_average_rate_of_change_defines.svh.
//
// Usage:
//   Input channel: sample with in_valid / in_stall; transfer when valid and not stall.
//   Output channel: average, percent_change, prev_zero with out_valid / out_stall.
//   Config channel: cfg_data with cfg_valid / cfg_ready (always ready) writes
//   window_len; write it only while the block is idle. Reset value is 3.
//   Processing: the input transfer starts the window sum update, then the
//   average division, the difference, the scaling and the percent division;
//   the percent division is skipped when the previous average was zero.
//   Both divisions use the single shared restoring divider, which retires
//   two quotient bits per cycle; the block takes one sample at a time.
//   in_stall is high from the input transfer until the result is written
//   into the output register; a result waiting under out_stall holds the
//   block in its final step, so a stalled receiver backs up into in_stall.
//   Reset clears the window sum, fill count, ring pointer, last average and
//   the output valid; the ring contents stay undefined and are never used
//   before being written.
module moving_average_rate_of_change (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [marc_pkg::SAMPLE_BITS-1:0]   sample,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [marc_pkg::AVG_BITS-1:0]      average,
    output logic signed [marc_pkg::PCT_BITS-1:0] percent_change,
    output logic                               prev_zero,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [marc_pkg::LEN_BITS-1:0]      cfg_data
);
    import marc_pkg::*;

    `include "moving_average_rate_of_change_defines.svh"

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SUM     = 4'd1;
    localparam logic [3:0] S_DIV_AVG = 4'd2;
    localparam logic [3:0] S_AVG     = 4'd3;
    localparam logic [3:0] S_DIFF    = 4'd4;
    localparam logic [3:0] S_MUL     = 4'd5;
    localparam logic [3:0] S_DIV_PCT = 4'd6;
    localparam logic [3:0] S_OUT     = 4'd7;

    localparam logic [LEN_BITS-1:0]  MAX_LEN  = LEN_BITS'(MAX_WINDOW);
    localparam logic [PCT_BITS-1:0]  PCT_MAX  = {1'b0, {(PCT_BITS-1){1'b1}}};
    localparam logic [PCT_BITS-1:0]  PCT_MIN  = PCT_BITS'(-PCT_SCALE);
    localparam logic [SCALE_BITS-1:0] SCALE_K = SCALE_BITS'(PCT_SCALE);

    // control state
    logic [3:0]              state_reg, state_next;
    logic [LEN_BITS-1:0]     window_len_reg;
    logic [PTR_BITS-1:0]     ptr_reg, ptr_next;
    logic [LEN_BITS-1:0]     fill_reg, fill_next;
    logic [SUM_BITS-1:0]     sum_reg, sum_next;
    logic [AVG_BITS-1:0]     last_avg_reg, last_avg_next;
    logic [CNT_BITS-1:0]     cnt_reg, cnt_next;
    logic                    out_valid_reg, out_valid_next;

    // payload
    logic [SAMPLE_BITS-1:0]  sample_reg, sample_next;
    logic [LEN_BITS-1:0]     len_reg, len_next;
    logic                    drop_reg, drop_next;
    div_state_t              div_reg, div_next;
    logic [AVG_BITS-1:0]     divisor_reg, divisor_next;
    logic [AVG_BITS-1:0]     avg_reg, avg_next;
    logic [AVG_BITS-1:0]     mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic                    flag_reg, flag_next;
    logic [AVG_BITS-1:0]     average_reg, average_next;
    logic [PCT_BITS-1:0]     pct_reg, pct_next;
    logic                    prev_zero_reg, prev_zero_next;

    // sample ring
    logic [SAMPLE_BITS-1:0]  ring [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]  ring_rdata_reg;

    logic                    in_xfer;
    logic                    out_xfer;
    logic [LEN_BITS-1:0]     len_eff;
    logic [PTR_BITS-1:0]     old_addr;
    logic [SUM_BITS-1:0]     sum_upd;
    div_state_t              div_step1, div_step2;
    logic [AVG_Q_BITS-1:0]   avg_q;
    logic [PROD_BITS-1:0]    product;
    logic [DIV_BITS-1:0]     pct_q;
    logic                    out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_xfer  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign out_valid      = out_valid_reg;
    assign average        = average_reg;
    assign percent_change = pct_reg;
    assign prev_zero      = prev_zero_reg;

    always_comb
    begin
        if (window_len_reg == '0)
        begin
            len_eff = LEN_BITS'(1);
        end
        else if (window_len_reg > MAX_LEN)
        begin
            len_eff = MAX_LEN;
        end
        else
        begin
            len_eff = window_len_reg;
        end
    end

    // slot written N items ago; a full-size window wraps onto the current slot
    assign old_addr = ptr_reg - len_eff[PTR_BITS-1:0];

    assign sum_upd = sum_reg + SUM_BITS'(sample_reg)
                     - (drop_reg ? SUM_BITS'(ring_rdata_reg) : SUM_BITS'(0));

    assign div_step1 = div_step(div_reg, divisor_reg);
    assign div_step2 = div_step(div_step1, divisor_reg);

    assign avg_q   = div_reg.dvd[AVG_Q_BITS-1:0];
    assign product = PROD_BITS'(mag_reg) * PROD_BITS'(SCALE_K);
    assign pct_q   = div_reg.dvd;

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        sum_next       = sum_reg;
        last_avg_next  = last_avg_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        sample_next    = sample_reg;
        len_next       = len_reg;
        drop_next      = drop_reg;
        div_next       = div_reg;
        divisor_next   = divisor_reg;
        avg_next       = avg_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        flag_next      = flag_reg;
        average_next   = average_reg;
        pct_next       = pct_reg;
        prev_zero_next = prev_zero_reg;

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sample_next = sample;
                    len_next    = len_eff;
                    drop_next   = !(fill_reg < len_eff);
                    state_next  = S_SUM;
                end
            end
            S_SUM:
            begin
                sum_next     = sum_upd;
                ptr_next     = ptr_reg + PTR_BITS'(1);
                if (fill_reg < MAX_LEN)
                begin
                    fill_next = fill_reg + LEN_BITS'(1);
                end
                div_next.rem = '0;
                div_next.dvd = DIV_BITS'({sum_upd, 8'b0}) << (DIV_BITS - AVG_Q_BITS);
                divisor_next = AVG_BITS'(len_reg);
                cnt_next     = CNT_BITS'(AVG_CYCLES - 1);
                state_next   = S_DIV_AVG;
            end
            S_DIV_AVG:
            begin
                div_next = div_step2;
                if (cnt_reg == '0)
                begin
                    state_next = S_AVG;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_BITS'(1);
                end
            end
            S_AVG:
            begin
                if (|avg_q[AVG_Q_BITS-1:AVG_BITS])
                begin
                    avg_next = '1;
                end
                else
                begin
                    avg_next = avg_q[AVG_BITS-1:0];
                end
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                neg_next  = (avg_reg < last_avg_reg);
                mag_next  = (avg_reg < last_avg_reg) ? (last_avg_reg - avg_reg)
                                                     : (avg_reg - last_avg_reg);
                flag_next = (last_avg_reg == '0);
                if (last_avg_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                div_next.rem = '0;
                div_next.dvd = DIV_BITS'(product);
                divisor_next = last_avg_reg;
                cnt_next     = CNT_BITS'(PCT_CYCLES - 1);
                state_next   = S_DIV_PCT;
            end
            S_DIV_PCT:
            begin
                div_next = div_step2;
                if (cnt_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_BITS'(1);
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    priority if (flag_reg)
                    begin
                        pct_next = '0;
                    end
                    else if (neg_reg)
                    begin
                        pct_next = (pct_q > DIV_BITS'(PCT_SCALE)) ? PCT_MIN
                                                                 : -pct_q[PCT_BITS-1:0];
                    end
                    else
                    begin
                        pct_next = (pct_q > DIV_BITS'(PCT_MAX)) ? PCT_MAX
                                                               : pct_q[PCT_BITS-1:0];
                    end
                    average_next   = avg_reg;
                    prev_zero_next = flag_reg;
                    last_avg_next  = avg_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            window_len_reg <= LEN_BITS'(3);
            ptr_reg        <= '0;
            fill_reg       <= '0;
            sum_reg        <= '0;
            last_avg_reg   <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            sum_reg       <= sum_next;
            last_avg_reg  <= last_avg_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                window_len_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        len_reg       <= len_next;
        drop_reg      <= drop_next;
        div_reg       <= div_next;
        divisor_reg   <= divisor_next;
        avg_reg       <= avg_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        flag_reg      <= flag_next;
        average_reg   <= average_next;
        pct_reg       <= pct_next;
        prev_zero_reg <= prev_zero_next;
    end

    // read the outgoing slot on the input transfer, write the new sample in the next cycle, in S_SUM
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SUM)
        begin
            ring[ptr_reg] <= sample_reg;
        end
        if (in_xfer)
        begin
            ring_rdata_reg <= ring[old_addr];
        end
    end

    `MARC_ASSERT(a_accept_starts_sum, (in_valid && !in_stall) |=> (state_reg == S_SUM), "transfer did not start the window update")
    `MARC_ASSERT(a_result_from_out, $rose(out_valid) |-> ($past(state_reg) == S_OUT), "result appeared outside the final step")
    `MARC_ASSERT(a_zero_prev_pct, (out_valid && prev_zero) |-> (percent_change == '0), "percent nonzero with zero previous average")
    `MARC_ASSERT_ALWAYS(a_fill_bound, fill_reg <= MAX_LEN, "fill count beyond window capacity")

endmodule
